[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define BXF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define BXF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[rtl/bxf_pkg.sv]
`timescale 1ns / 1ps

package bxf_pkg;

  localparam int PIX_FIELD_BITS   = 8;
  localparam int ROW_FIELD_BITS   = 12;
  localparam int COL_FIELD_BITS   = 10;
  localparam int VALUE_FIELD_BITS = 8;

  localparam int CFG_IDX_BITS     = 4;
  localparam int CFG_DATA_BITS    = 13;
  localparam int IMAGE_WIDTH_BITS  = 11;
  localparam int IMAGE_HEIGHT_BITS = 13;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 4'd1;

  localparam int IMAGE_WIDTH_RST  = 640;
  localparam int IMAGE_HEIGHT_RST = 480;

  typedef struct packed {
    logic [PIX_FIELD_BITS-1:0] pixel_value;
  } pix_t;

  typedef struct packed {
    logic [ROW_FIELD_BITS-1:0]   out_row;
    logic [COL_FIELD_BITS-1:0]   out_col;
    logic [VALUE_FIELD_BITS-1:0] out_value;
    logic                        end_of_run;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  reg_index;
    logic [CFG_DATA_BITS-1:0] wdata;
  } cfg_t;

endpackage

[rtl/bxf_pix_if.sv]
`timescale 1ns / 1ps

interface bxf_pix_if;
  logic          valid;
  logic          ready;
  bxf_pkg::pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/bxf_res_if.sv]
`timescale 1ns / 1ps

interface bxf_res_if;
  logic          valid;
  logic          ready;
  bxf_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/bxf_cfg_if.sv]
`timescale 1ns / 1ps

interface bxf_cfg_if;
  logic          valid;
  logic          ready;
  bxf_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/bxf_line_mem.sv]
`timescale 1ns / 1ps

// Two-row line store, one entry per column: {two rows above, row above}.
// Registered read with write-first bypass for a same-cycle hit.
module bxf_line_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/bxf_window.sv]
`timescale 1ns / 1ps

// Two left columns of the 3x3 window and the neighbourhood adder.
module bxf_window #(
  parameter int PW = 8,
  parameter int SW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic [PW-1:0] pix_i,
  input  logic [PW-1:0] above_i,
  input  logic [PW-1:0] two_above_i,
  output logic [SW-1:0] sum_o
);

  // [0..2]: left column (two above, above, current row), [3..5]: one further left
  logic [PW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= two_above_i;
      win_q[1] <= above_i;
      win_q[2] <= pix_i;
    end
  end

  always_comb begin
    sum_o = SW'(pix_i) + SW'(above_i) + SW'(two_above_i);
    for (int i = 0; i < 6; i++) begin
      sum_o = sum_o + SW'(win_q[i]);
    end
  end

endmodule

[rtl/bxf_div9.sv]
`timescale 1ns / 1ps

// Truncating divide by nine: multiply by a rounded-up reciprocal and shift.
// Exact for every sum below 2**SW whose quotient fits in QW bits.
module bxf_div9 #(
  parameter int SW = 12,
  parameter int QW = 8
) (
  input  logic [SW-1:0] sum_i,
  output logic [QW-1:0] quot_o
);

  localparam int K  = SW + 3;
  localparam int PW = SW + K;
  localparam longint unsigned RECIP = ((64'd1 << K) + 64'd8) / 64'd9;

  logic [PW-1:0] prod;

  assign prod   = PW'(sum_i) * PW'(RECIP);
  assign quot_o = prod[K+QW-1:K];

endmodule

[rtl/box_filter_3x3_smoothing_core.sv]
// Each pixel goes through the line store read, the 3x3 sum and then the output register.
// Throughput: one pixel per clock while results are taken; a pixel with both an interior
// mean and a border pass-through holds the single output register until both are taken.
// Reset: counters, window and pipeline valids clear, frame size returns to 640x480;
// the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module box_filter_3x3_smoothing_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bxf_pix_if.sink    pix_i,
  bxf_res_if.source  res_o,
  bxf_cfg_if.sink    cfg_i
);

  localparam int CW = $clog2(MAX_WIDTH);   // column counter / line store address
  localparam int RW = $clog2(MAX_HEIGHT);  // row counter
  localparam int PW = PIXEL_BITS;
  localparam int SW = PIXEL_BITS + 4;      // 3x3 sum

  localparam int W_RST = (bxf_pkg::IMAGE_WIDTH_RST > MAX_WIDTH) ?
                         MAX_WIDTH : bxf_pkg::IMAGE_WIDTH_RST;
  localparam int H_RST = (bxf_pkg::IMAGE_HEIGHT_RST > MAX_HEIGHT) ?
                         MAX_HEIGHT : bxf_pkg::IMAGE_HEIGHT_RST;

  // ---------------------------------------------------------------------------
  // Frame size. Stored as last column / last row index, already clamped
  // (zero acts as one, anything above the maximum acts as the maximum).
  // ---------------------------------------------------------------------------
  logic [CW-1:0] w_last_q, w_last_d;
  logic [RW-1:0] h_last_q, h_last_d;
  logic [bxf_pkg::IMAGE_WIDTH_BITS-1:0]  cfg_w;
  logic [bxf_pkg::IMAGE_HEIGHT_BITS-1:0] cfg_h;

  assign cfg_i.ready = 1'b1;
  assign cfg_w = cfg_i.data.wdata[bxf_pkg::IMAGE_WIDTH_BITS-1:0];
  assign cfg_h = cfg_i.data.wdata[bxf_pkg::IMAGE_HEIGHT_BITS-1:0];

  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        bxf_pkg::CFG_IMAGE_WIDTH: begin
          if (cfg_w == '0) begin
            w_last_d = '0;
          end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
            w_last_d = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_d = CW'(cfg_w - 1'b1);
          end
        end
        bxf_pkg::CFG_IMAGE_HEIGHT: begin
          if (cfg_h == '0) begin
            h_last_d = '0;
          end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
            h_last_d = RW'(MAX_HEIGHT - 1);
          end else begin
            h_last_d = RW'(cfg_h - 1'b1);
          end
        end
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= CW'(W_RST - 1);
      h_last_q <= RW'(H_RST - 1);
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. Stage 1 waits on the line store read, stage 2 holds
  // the 3x3 sum, stage 3 is the output register with up to two results.
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s3_int_pend_q, s3_bord_q;
  logic s3_last, s3_free, s2_free, s1_adv, pix_xfer, res_xfer;

  assign res_xfer = res_o.valid && res_o.ready;
  assign s3_last  = !s3_int_pend_q || !s3_bord_q;
  assign s3_free  = !s3_v_q || (res_o.ready && s3_last);
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_adv   = s1_v_q && s2_free;
  assign pix_i.ready = !s1_v_q || s2_free;
  assign pix_xfer = pix_i.valid && pix_i.ready;

  // ---------------------------------------------------------------------------
  // Raster counters and classification, done at input transfer.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          is_int, is_bord;
  logic [PW-1:0] pix_in;

  assign pix_in  = PW'(pix_i.data.pixel_value);
  assign is_int  = (row_q >= RW'(2)) && (col_q >= CW'(2)) &&
                   (row_q <= h_last_q) && (col_q <= w_last_q);
  assign is_bord = (row_q == '0) || (row_q >= h_last_q) ||
                   (col_q == '0) || (col_q >= w_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (pix_xfer) begin
      if (col_q >= w_last_q) begin
        col_q <= '0;
        row_q <= (row_q >= h_last_q) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read data arrives; the pixel leaves into stage 2 and
  // writes its column back ({row above, this pixel}) as it goes.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] s1_pix_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_int_q, s1_bord_q;
  logic [2*PW-1:0] line_rd;
  logic [PW-1:0] above, two_above;
  logic [SW-1:0] win_sum;

  bxf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PW),
    .AW    (CW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (pix_xfer),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({above, s1_pix_q})
  );

  assign above     = line_rd[PW-1:0];
  assign two_above = line_rd[2*PW-1:PW];

  bxf_window #(
    .PW (PW),
    .SW (SW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_adv),
    .pix_i       (s1_pix_q),
    .above_i     (above),
    .two_above_i (two_above),
    .sum_o       (win_sum)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: sum held, divided by nine on the way into stage 3.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] s2_sum_q;
  logic [PW-1:0] s2_pix_q;
  logic [RW-1:0] s2_row_q;
  logic [CW-1:0] s2_col_q;
  logic          s2_int_q, s2_bord_q;
  logic [PW-1:0] mean;

  bxf_div9 #(
    .SW (SW),
    .QW (PW)
  ) u_div9 (
    .sum_i  (s2_sum_q),
    .quot_o (mean)
  );

  // Stage 3 payload
  logic [PW-1:0] s3_mean_q, s3_pix_q;
  logic [RW-1:0] s3_row_q;
  logic [CW-1:0] s3_col_q;

  // valid / result-pending flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q        <= 1'b0;
      s2_v_q        <= 1'b0;
      s3_v_q        <= 1'b0;
      s3_int_pend_q <= 1'b0;
      s3_bord_q     <= 1'b0;
    end else begin
      if (pix_i.ready) begin
        s1_v_q <= pix_i.valid;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_free) begin
        // a pixel with no result never occupies the output register
        s3_v_q        <= s2_v_q && (s2_int_q || s2_bord_q);
        s3_int_pend_q <= s2_v_q && s2_int_q;
        s3_bord_q     <= s2_v_q && s2_bord_q;
      end else if (res_xfer) begin
        // interior result went out, border pass-through follows
        s3_int_pend_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      s1_pix_q  <= pix_in;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_int_q  <= is_int;
      s1_bord_q <= is_bord;
    end
    if (s1_adv) begin
      s2_sum_q  <= win_sum;
      s2_pix_q  <= s1_pix_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_int_q  <= s1_int_q;
      s2_bord_q <= s1_bord_q;
    end
    if (s3_free && s2_v_q) begin
      s3_mean_q <= mean;
      s3_pix_q  <= s2_pix_q;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: interior mean (for the pixel up and left) first, then border.
  // ---------------------------------------------------------------------------
  always_comb begin
    res_o.valid = s3_v_q;
    if (s3_int_pend_q) begin
      res_o.data.out_row    = bxf_pkg::ROW_FIELD_BITS'(s3_row_q - 1'b1);
      res_o.data.out_col    = bxf_pkg::COL_FIELD_BITS'(s3_col_q - 1'b1);
      res_o.data.out_value  = bxf_pkg::VALUE_FIELD_BITS'(s3_mean_q);
      res_o.data.end_of_run = !s3_bord_q;
    end else begin
      res_o.data.out_row    = bxf_pkg::ROW_FIELD_BITS'(s3_row_q);
      res_o.data.out_col    = bxf_pkg::COL_FIELD_BITS'(s3_col_q);
      res_o.data.out_value  = bxf_pkg::VALUE_FIELD_BITS'(s3_pix_q);
      res_o.data.end_of_run = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BXF_ASSERT(a_pair_keeps_border, clk_i, rst_ni,
              res_xfer && s3_int_pend_q && s3_bord_q |=> s3_v_q && !s3_int_pend_q)
  `BXF_ASSERT(a_stage1_stall_holds, clk_i, rst_ni,
              s1_v_q && !s2_free |=> s1_v_q && $stable(s1_pix_q) && $stable(s1_col_q))
  `BXF_ASSERT(a_pending_needs_valid, clk_i, rst_ni,
              !s3_int_pend_q || s3_v_q)

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int LINE_LEN      = 1024;
  localparam int ROWS_MAX      = 4096;
  localparam int PIX_BITS      = 8;
  localparam int RANDOM_PIXELS = 650;
  // receiver hold-off long enough to back the whole pipe up into the input
  localparam int LONG_HOLD     = 400;
  // margin for a pixel with no result to leave the pipe before touching registers
  localparam int SETTLE_CYCLES = 4;
  localparam int WIDTH_ONES    = (1 << bxf_pkg::IMAGE_WIDTH_BITS) - 1;
  localparam int HEIGHT_ONES   = (1 << bxf_pkg::IMAGE_HEIGHT_BITS) - 1;
  // index with no register behind it: the write must be dropped
  localparam logic [bxf_pkg::CFG_IDX_BITS-1:0] CFG_UNMAPPED = 4'hF;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  bxf_pix_if pix_if ();
  bxf_res_if res_if ();
  bxf_cfg_if cfg_if ();

  box_filter_3x3_smoothing_core #(
    .MAX_WIDTH  (LINE_LEN),
    .MAX_HEIGHT (ROWS_MAX),
    .PIXEL_BITS (PIX_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Filter state as the block should hold it, advanced on every transfer.
  // ---------------------------------------------------------------------------
  logic [bxf_pkg::IMAGE_WIDTH_BITS-1:0]  width_reg;
  logic [bxf_pkg::IMAGE_HEIGHT_BITS-1:0] height_reg;
  logic [bxf_pkg::ROW_FIELD_BITS-1:0]    row_now;
  logic [bxf_pkg::COL_FIELD_BITS-1:0]    col_now;
  // row_m1 = line just above, row_m2 = two lines above (zero until written)
  logic [PIX_BITS-1:0] row_m1 [LINE_LEN] = '{default: '0};
  logic [PIX_BITS-1:0] row_m2 [LINE_LEN] = '{default: '0};
  // [0..2] = column c-1 (two above, above, current row), [3..5] = column c-2
  logic [PIX_BITS-1:0] window_px [6];

  logic [bxf_pkg::PIX_FIELD_BITS-1:0] pixels_to_send [$];
  bxf_pkg::res_t results_due [$];

  int   errors       = 0;
  int   fed_pixels   = 0;
  int   holds_asked  = 0;
  int   holds_served = 0;
  logic pix_took     = 1'b0;

  // a size register of 0 behaves as 1, anything past the line length or row limit saturates
  function automatic int clamp_w(input logic [bxf_pkg::IMAGE_WIDTH_BITS-1:0] raw);
    if (raw == 0) return 1;
    if (raw > LINE_LEN) return LINE_LEN;
    return int'(raw);
  endfunction

  function automatic int clamp_h(input logic [bxf_pkg::IMAGE_HEIGHT_BITS-1:0] raw);
    if (raw == 0) return 1;
    if (raw > ROWS_MAX) return ROWS_MAX;
    return int'(raw);
  endfunction

  // One accepted pixel: queue the mean it completes (if any), then its own
  // pass-through (if it sits on the border), and roll the line/window state.
  task automatic filter_step(input logic [bxf_pkg::PIX_FIELD_BITS-1:0] px);
    int w, h, r, c, idx, sum;
    logic [PIX_BITS-1:0] v, up1, up2;
    logic on_border;
    bxf_pkg::res_t mean_res, pass_res;
    w = clamp_w(width_reg);
    h = clamp_h(height_reg);
    v = px[PIX_BITS-1:0];
    r = int'(row_now);
    c = int'(col_now);
    idx = (c < LINE_LEN) ? c : LINE_LEN - 1;
    up1 = row_m1[idx];
    up2 = row_m2[idx];
    // counters left past the frame by a mid-frame resize count as border too
    on_border = (r == 0) || (r >= h - 1) || (c == 0) || (c >= w - 1);

    // pixel (r,c) closes the 3x3 window centered on (r-1,c-1)
    if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
      sum = int'(v) + int'(up1) + int'(up2);
      foreach (window_px[i]) sum += int'(window_px[i]);
      mean_res.out_row    = bxf_pkg::ROW_FIELD_BITS'(r - 1);
      mean_res.out_col    = bxf_pkg::COL_FIELD_BITS'(c - 1);
      mean_res.out_value  = bxf_pkg::VALUE_FIELD_BITS'(sum / 9);
      mean_res.end_of_run = !on_border;
      results_due.push_back(mean_res);
    end
    if (on_border) begin
      pass_res.out_row    = bxf_pkg::ROW_FIELD_BITS'(r);
      pass_res.out_col    = bxf_pkg::COL_FIELD_BITS'(c);
      pass_res.out_value  = v;
      pass_res.end_of_run = 1'b1;
      results_due.push_back(pass_res);
    end

    row_m2[idx]  = up1;
    row_m1[idx]  = v;
    window_px[3] = window_px[0];
    window_px[4] = window_px[1];
    window_px[5] = window_px[2];
    window_px[0] = up2;
    window_px[1] = up1;
    window_px[2] = v;

    if (c >= w - 1) begin
      col_now = '0;
      row_now = (r >= h - 1) ? '0 : bxf_pkg::ROW_FIELD_BITS'(r + 1);
    end else begin
      col_now = bxf_pkg::COL_FIELD_BITS'(c + 1);
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", field, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, where transfers happen.
  // Register writes are applied first; they only happen while idle anyway.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_took <= pix_if.valid && pix_if.ready;
    if (!rst_ni) begin
      width_reg  = bxf_pkg::IMAGE_WIDTH_BITS'(bxf_pkg::IMAGE_WIDTH_RST);
      height_reg = bxf_pkg::IMAGE_HEIGHT_BITS'(bxf_pkg::IMAGE_HEIGHT_RST);
      row_now    = '0;
      col_now    = '0;
      foreach (window_px[i]) window_px[i] = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data.reg_index == bxf_pkg::CFG_IMAGE_WIDTH)
          width_reg = cfg_if.data.wdata[bxf_pkg::IMAGE_WIDTH_BITS-1:0];
        else if (cfg_if.data.reg_index == bxf_pkg::CFG_IMAGE_HEIGHT)
          height_reg = cfg_if.data.wdata[bxf_pkg::IMAGE_HEIGHT_BITS-1:0];
      end
      if (pix_if.valid && pix_if.ready) filter_step(pix_if.data.pixel_value);
      if (res_if.valid && res_if.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: row %0d col %0d value %0d",
                 res_if.data.out_row, res_if.data.out_col, res_if.data.out_value);
          errors++;
        end else begin
          check_field("out_row", results_due[0].out_row, res_if.data.out_row);
          check_field("out_col", results_due[0].out_col, res_if.data.out_col);
          check_field("out_value", results_due[0].out_value, res_if.data.out_value);
          check_field("end_of_run", results_due[0].end_of_run, res_if.data.end_of_run);
          void'(results_due.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver: bursts of random length, now and then a long one, each followed
  // by a random gap or by none. Holds the item until its transfer.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!pix_if.valid || pix_took)) begin
      if (gap_left != 0) begin
        gap_left--;
        pix_if.valid <= 1'b0;
      end else if (pixels_to_send.size() != 0) begin
        pix_if.valid <= 1'b1;
        pix_if.data.pixel_value <= pixels_to_send.pop_front();
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: switches between always ready, coin flip, a rotating
  // bit pattern and mostly stalled. A requested long hold-off overrides all.
  // ---------------------------------------------------------------------------
  rx_mode_e   rx_mode      = RX_OPEN;
  int         rx_mode_left = 0;
  int         hold_left    = 0;
  logic [7:0] rx_pattern   = 8'h01;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left == 0 && holds_served != holds_asked) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 300);
        rx_pattern   = 8'($urandom) | 8'h01;
      end else begin
        rx_mode_left--;
      end
      rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:    res_if.ready <= 1'b1;
          RX_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: res_if.ready <= rx_pattern[0];
          default:    res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [bxf_pkg::PIX_FIELD_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_pixels(input int n);
    repeat (n) pixels_to_send.push_back(pick_pixel());
    fed_pixels += n;
  endtask

  // Wait until every queued pixel went across and every result came back,
  // then give a pixel with no result time to leave the pipe.
  task automatic settle();
    do @(posedge clk_i);
    while (pixels_to_send.size() != 0 || pix_if.valid || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bxf_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [bxf_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data.reg_index <= idx;
    cfg_if.data.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Feed pixels up to the end of the current frame. Needed before the row
  // grows, so no mean ever uses a line-store entry that was never written.
  task automatic finish_frame();
    int r, c, n;
    r = int'(row_now);
    c = int'(col_now);
    n = 0;
    while (r != 0 || c != 0) begin
      n++;
      if (c >= clamp_w(width_reg) - 1) begin
        c = 0;
        r = (r >= clamp_h(height_reg) - 1) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
    queue_pixels(n);
    settle();
  endtask

  task automatic resize(input logic [bxf_pkg::CFG_DATA_BITS-1:0] w_raw,
                        input logic [bxf_pkg::CFG_DATA_BITS-1:0] h_raw);
    settle();
    if (clamp_w(w_raw[bxf_pkg::IMAGE_WIDTH_BITS-1:0]) > clamp_w(width_reg)) finish_frame();
    write_reg(bxf_pkg::CFG_IMAGE_WIDTH, w_raw);
    write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, h_raw);
  endtask

  // Narrow the row and pick a short frame in the middle of a frame; the
  // counters may end up past the new edges and must wrap on their own.
  task automatic shrink_mid_frame();
    int w_cap;
    settle();
    w_cap = (clamp_w(width_reg) < 12) ? clamp_w(width_reg) : 12;
    write_reg(bxf_pkg::CFG_IMAGE_WIDTH, bxf_pkg::CFG_DATA_BITS'($urandom_range(1, w_cap)));
    write_reg(bxf_pkg::CFG_IMAGE_HEIGHT, bxf_pkg::CFG_DATA_BITS'($urandom_range(1, 6)));
    queue_pixels($urandom_range(1, 30));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int w, h, area;
    logic [bxf_pkg::PIX_FIELD_BITS-1:0] opening [11];
    opening = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h12,
                8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h33};
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Start of row 0 at the reset size (640x480).
    for (int i = 0; i < 4; i++) pixels_to_send.push_back(opening[i]);
    // Drop to 3x3 while the column counter already sits past the new row end:
    // that pixel is passed through and the row wraps. Row 2 col 2 then gives
    // both the mean for (1,1) and its own pass-through in one step.
    resize(bxf_pkg::CFG_DATA_BITS'(3), bxf_pkg::CFG_DATA_BITS'(3));
    for (int i = 4; i < 11; i++) pixels_to_send.push_back(opening[i]);
    // all-white frame: largest possible mean
    repeat (9) pixels_to_send.push_back(8'hFF);
    // 2x2 frame: border only, no mean at all
    resize(bxf_pkg::CFG_DATA_BITS'(2), bxf_pkg::CFG_DATA_BITS'(2));
    repeat (4) pixels_to_send.push_back(pick_pixel());

    // Full-width frame, one row, reaching the last line-store entry.
    // The receiver holds off for a long stretch at its start so the block
    // fills up and has to stall the pixel input.
    resize(bxf_pkg::CFG_DATA_BITS'(LINE_LEN), bxf_pkg::CFG_DATA_BITS'(1));
    queue_pixels(LINE_LEN);
    holds_asked++;

    // Random part
    fed_pixels = 0;
    while (fed_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        6: begin
          // thin frames: fewer than three rows or columns
          if ($urandom_range(0, 1) == 0) begin
            w = $urandom_range(1, 2);
            h = $urandom_range(1, 8);
          end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 2);
          end
          resize(bxf_pkg::CFG_DATA_BITS'(w), bxf_pkg::CFG_DATA_BITS'(h));
          queue_pixels($urandom_range(1, 30));
        end
        7: shrink_mid_frame();
        8: begin
          // register values at and beyond the limits, zero included; width
          // bits above the register are set in the written word now and then
          case ($urandom_range(0, 3))
            0:       w = 0;
            1:       w = LINE_LEN;
            2:       w = WIDTH_ONES;
            default: w = 13'h1800 | $urandom_range(3, 9);
          endcase
          case ($urandom_range(0, 3))
            0:       h = 0;
            1:       h = ROWS_MAX;
            2:       h = HEIGHT_ONES;
            default: h = $urandom_range(1, 4);
          endcase
          resize(bxf_pkg::CFG_DATA_BITS'(w), bxf_pkg::CFG_DATA_BITS'(h));
          queue_pixels($urandom_range(5, 60));
          shrink_mid_frame();
        end
        9: begin
          // a write to an index with no register must change nothing
          settle();
          write_reg(CFG_UNMAPPED, bxf_pkg::CFG_DATA_BITS'($urandom));
          queue_pixels($urandom_range(1, 30));
        end
        default: begin
          // ordinary small frames, whole ones plus maybe a partial one
          w = $urandom_range(3, 12);
          h = $urandom_range(3, 9);
          area = w * h;
          resize(bxf_pkg::CFG_DATA_BITS'(w), bxf_pkg::CFG_DATA_BITS'(h));
          queue_pixels(area * $urandom_range(1, 3) +
                       (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, area - 1)));
        end
      endcase
    end

    settle();
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  // Hard limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/bxf_pkg.sv
rtl/bxf_pix_if.sv
rtl/bxf_res_if.sv
rtl/bxf_cfg_if.sv
rtl/bxf_line_mem.sv
rtl/bxf_window.sv
rtl/bxf_div9.sv
rtl/box_filter_3x3_smoothing_core.sv
verif/tb.sv
